@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GFR_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GFR_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ design/gfr_pkg.sv @@
// Shared constants for the goal frame receiver: operation, status and register codes.
// No dependencies.
package gfr_pkg;

   localparam int SERVO_COUNT_DEFAULT = 16;
   localparam int HEADER_BYTES        = 5;
   localparam int GOAL_W              = 16;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 16;

   // Operation codes of the request channel
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_DONE         = 3'd0;
   localparam logic [2:0] ST_HDR_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_DATA_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_INVALID      = 3'd3;
   localparam logic [2:0] ST_PARTNER      = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_VALUE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_TYPE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTNER_TYPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HDR_TIMEOUT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TIMEOUT = 3'd4;

   // Register reset values
   localparam logic [7:0]  RST_SYNC_VALUE   = 8'hFF;
   localparam logic [7:0]  RST_GOAL_TYPE    = 8'd1;
   localparam logic [7:0]  RST_PARTNER_TYPE = 8'd2;
   localparam logic [15:0] RST_HDR_TIMEOUT  = 16'd5;
   localparam logic [15:0] RST_DATA_TIMEOUT = 16'd14;

endpackage

@@ design/goal_frame_receiver.sv @@
// Goal frame receiver top level: header/data sequencer, timers and result register.
// Depends on gfr_pkg and gfr_goal_store.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_operation, req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_goal_valid, rsp_servo_index,
//          |           |                     | rsp_goal_position, rsp_last
//  csr     | in        | csr_wr_en           | csr_index, csr_wr_data
//
// A byte, tick or period start is taken in S_ACCEPT. An item that reports a status
// holds the request side in S_EMIT until the result is loaded into the output
// register. A completed good frame drains SERVO_COUNT results, each through S_RD and
// then S_OUT, through the single read port of the goal store.
// Reset is synchronous and restores the register defaults; the store needs no clearing.
// A stalled result holds the sequencer in S_EMIT or S_OUT until the output register frees up.
module goal_frame_receiver
   import gfr_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_operation,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic                   rsp_goal_valid,
   output logic [5:0]             rsp_servo_index,
   output logic signed [15:0]     rsp_goal_position,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int PAYLOAD_BYTES = 2 * SERVO_COUNT;
   localparam int CNT_W  = ($clog2(PAYLOAD_BYTES) > 3) ? $clog2(PAYLOAD_BYTES) : 3;
   localparam int ADDR_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [7:0] FRAME_LEN = 8'(HEADER_BYTES + PAYLOAD_BYTES);

   typedef enum logic [1:0] {
      S_ACCEPT,
      S_EMIT,
      S_RD,
      S_OUT
   } seq_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_DATA
   } phase_type;

   seq_type         seq_ff, seq_in;
   phase_type       phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       tick_ff, tick_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        length_ff, length_in;
   logic [7:0]        check_ff, check_in;
   logic [7:0]        xor_ff, xor_in;
   logic              sync_bad_ff, sync_bad_in;
   logic [7:0]        hi_ff, hi_in;
   logic [2:0]        pend_ff, pend_in;
   logic [ADDR_W-1:0] k_ff, k_in;

   logic [7:0]  sync_value_ff, sync_value_in;
   logic [7:0]  goal_type_ff, goal_type_in;
   logic [7:0]  partner_type_ff, partner_type_in;
   logic [15:0] hdr_to_ff, hdr_to_in;
   logic [15:0] data_to_ff, data_to_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_goal_valid_ff, rsp_goal_valid_in;
   logic [5:0]        rsp_index_ff, rsp_index_in;
   logic [15:0]       rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic              load;
   logic [15:0]       tick_inc;
   logic [7:0]        xor_next;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic              mem_rd_en;
   logic [GOAL_W-1:0] mem_rd_data;

   assign req_stall = (seq_ff != S_ACCEPT);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tick_inc  = tick_ff + 16'd1;
   assign xor_next  = xor_ff ^ req_rx_byte;
   assign mem_wr_addr = cnt_ff[ADDR_W:1];

   gfr_goal_store #(
      .DEPTH  (SERVO_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (GOAL_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data ({hi_ff, req_rx_byte}),
      .rd_en   (mem_rd_en),
      .rd_addr (k_ff),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      seq_in      = seq_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      tick_in     = tick_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      check_in    = check_ff;
      xor_in      = xor_ff;
      sync_bad_in = sync_bad_ff;
      hi_in       = hi_ff;
      pend_in     = pend_ff;
      k_in        = k_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      load        = 1'b0;

      rsp_status_in     = rsp_status_ff;
      rsp_goal_valid_in = rsp_goal_valid_ff;
      rsp_index_in      = rsp_index_ff;
      rsp_pos_in        = rsp_pos_ff;
      rsp_last_in       = rsp_last_ff;

      sync_value_in   = sync_value_ff;
      goal_type_in    = goal_type_ff;
      partner_type_in = partner_type_ff;
      hdr_to_in       = hdr_to_ff;
      data_to_in      = data_to_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC_VALUE:   sync_value_in   = csr_wr_data[7:0];
            CSR_GOAL_TYPE:    goal_type_in    = csr_wr_data[7:0];
            CSR_PARTNER_TYPE: partner_type_in = csr_wr_data[7:0];
            CSR_HDR_TIMEOUT:  hdr_to_in       = csr_wr_data;
            CSR_DATA_TIMEOUT: data_to_in      = csr_wr_data;
            default: ;
         endcase
      end

      unique case (seq_ff)
         S_ACCEPT: begin
            if (accept) begin
               unique case (req_operation)
                  OP_START: begin
                     phase_in    = PH_HEADER;
                     cnt_in      = '0;
                     tick_in     = '0;
                     xor_in      = '0;
                     sync_bad_in = 1'b0;
                  end
                  OP_BYTE: begin
                     if (phase_ff == PH_HEADER) begin
                        if (cnt_ff < CNT_W'(2)) begin
                           if (req_rx_byte != sync_value_ff) begin
                              sync_bad_in = 1'b1;
                           end
                        end else if (cnt_ff == CNT_W'(2)) begin
                           type_in = req_rx_byte;
                        end else if (cnt_ff == CNT_W'(3)) begin
                           length_in = req_rx_byte;
                        end else begin
                           check_in = req_rx_byte;
                        end
                        cnt_in = cnt_ff + CNT_W'(1);
                        if (cnt_ff == CNT_W'(HEADER_BYTES - 1)) begin
                           // judge the header: sync, partner error, type, length
                           if (sync_bad_ff || type_ff == partner_type_ff ||
                               type_ff != goal_type_ff || length_ff != FRAME_LEN) begin
                              pend_in     = (!sync_bad_ff && type_ff == partner_type_ff) ?
                                            ST_PARTNER : ST_INVALID;
                              seq_in      = S_EMIT;
                              phase_in    = PH_HEADER;
                              cnt_in      = '0;
                              tick_in     = '0;
                              xor_in      = '0;
                              sync_bad_in = 1'b0;
                           end else begin
                              phase_in = PH_DATA;
                              cnt_in   = '0;
                              tick_in  = '0;
                              xor_in   = type_ff ^ length_ff;
                           end
                        end
                     end else if (phase_ff == PH_DATA) begin
                        // pair bytes high first into one goal word
                        if (cnt_ff[0]) begin
                           mem_wr_en = 1'b1;
                        end else begin
                           hi_in = req_rx_byte;
                        end
                        xor_in = xor_next;
                        cnt_in = cnt_ff + CNT_W'(1);
                        if (cnt_ff == CNT_W'(PAYLOAD_BYTES - 1)) begin
                           if (xor_next != check_ff) begin
                              pend_in     = ST_INVALID;
                              seq_in      = S_EMIT;
                              phase_in    = PH_HEADER;
                              cnt_in      = '0;
                              tick_in     = '0;
                              xor_in      = '0;
                              sync_bad_in = 1'b0;
                           end else begin
                              phase_in = PH_IDLE;
                              cnt_in   = '0;
                              tick_in  = '0;
                              k_in     = '0;
                              seq_in   = S_RD;
                           end
                        end
                     end
                  end
                  OP_TICK: begin
                     if (phase_ff == PH_HEADER && hdr_to_ff != 16'd0) begin
                        tick_in = tick_inc;
                        if (tick_inc >= hdr_to_ff) begin
                           phase_in = PH_IDLE;
                           cnt_in   = '0;
                           tick_in  = '0;
                           pend_in  = ST_HDR_TIMEOUT;
                           seq_in   = S_EMIT;
                        end
                     end else if (phase_ff == PH_DATA && data_to_ff != 16'd0) begin
                        tick_in = tick_inc;
                        if (tick_inc >= data_to_ff) begin
                           phase_in    = PH_HEADER;
                           cnt_in      = '0;
                           tick_in     = '0;
                           xor_in      = '0;
                           sync_bad_in = 1'b0;
                           pend_in     = ST_DATA_TIMEOUT;
                           seq_in      = S_EMIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load              = 1'b1;
               rsp_status_in     = pend_ff;
               rsp_goal_valid_in = 1'b0;
               rsp_index_in      = '0;
               rsp_pos_in        = '0;
               rsp_last_in       = 1'b1;
               seq_in            = S_ACCEPT;
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            seq_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               load              = 1'b1;
               rsp_status_in     = ST_DONE;
               rsp_goal_valid_in = 1'b1;
               rsp_index_in      = 6'(k_ff) + 6'd1;
               rsp_pos_in        = mem_rd_data;
               rsp_last_in       = (k_ff == ADDR_W'(SERVO_COUNT - 1));
               if (k_ff == ADDR_W'(SERVO_COUNT - 1)) begin
                  seq_in = S_ACCEPT;
               end else begin
                  k_in   = k_ff + ADDR_W'(1);
                  seq_in = S_RD;
               end
            end
         end
         default: ;
      endcase

      // hold while stalled, drop once taken
      rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff            <= S_ACCEPT;
         phase_ff          <= PH_IDLE;
         cnt_ff            <= '0;
         tick_ff           <= '0;
         type_ff           <= '0;
         length_ff         <= '0;
         check_ff          <= '0;
         xor_ff            <= '0;
         sync_bad_ff       <= 1'b0;
         hi_ff             <= '0;
         pend_ff           <= ST_DONE;
         k_ff              <= '0;
         sync_value_ff     <= RST_SYNC_VALUE;
         goal_type_ff      <= RST_GOAL_TYPE;
         partner_type_ff   <= RST_PARTNER_TYPE;
         hdr_to_ff         <= RST_HDR_TIMEOUT;
         data_to_ff        <= RST_DATA_TIMEOUT;
         rsp_valid_ff      <= 1'b0;
         rsp_status_ff     <= ST_DONE;
         rsp_goal_valid_ff <= 1'b0;
         rsp_index_ff      <= '0;
         rsp_pos_ff        <= '0;
         rsp_last_ff       <= 1'b0;
      end else begin
         seq_ff            <= seq_in;
         phase_ff          <= phase_in;
         cnt_ff            <= cnt_in;
         tick_ff           <= tick_in;
         type_ff           <= type_in;
         length_ff         <= length_in;
         check_ff          <= check_in;
         xor_ff            <= xor_in;
         sync_bad_ff       <= sync_bad_in;
         hi_ff             <= hi_in;
         pend_ff           <= pend_in;
         k_ff              <= k_in;
         sync_value_ff     <= sync_value_in;
         goal_type_ff      <= goal_type_in;
         partner_type_ff   <= partner_type_in;
         hdr_to_ff         <= hdr_to_in;
         data_to_ff        <= data_to_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_goal_valid_ff <= rsp_goal_valid_in;
         rsp_index_ff      <= rsp_index_in;
         rsp_pos_ff        <= rsp_pos_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_goal_valid    = rsp_goal_valid_ff;
   assign rsp_servo_index   = rsp_index_ff;
   assign rsp_goal_position = $signed(rsp_pos_ff);
   assign rsp_last          = rsp_last_ff;

endmodule

@@ design/gfr_goal_store.sv @@
// Goal payload store: one 16-bit goal word per servo, one write and one
// registered read port. No package dependencies.
module gfr_goal_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/gfr_checker.sv @@
// Port-level checker for goal_frame_receiver, bound to the top level below.
// Depends on gfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gfr_checker
   import gfr_pkg::*;
#(
   parameter int SERVO_COUNT = SERVO_COUNT_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_status,
   input logic               rsp_goal_valid,
   input logic [5:0]         rsp_servo_index,
   input logic signed [15:0] rsp_goal_position,
   input logic               rsp_last
);

   logic [26:0] rsp_payload;
   logic        rsp_waiting;
   logic        goal_out;
   logic        status_out;
   logic        burst_open;
   logic        index_ok;
   logic        goal_empty;

   assign rsp_payload = {rsp_status, rsp_goal_valid, rsp_servo_index, rsp_goal_position,
                         rsp_last};
   assign rsp_waiting = rsp_valid && rsp_stall;
   assign goal_out    = rsp_valid && rsp_goal_valid;
   assign status_out  = rsp_valid && !rsp_goal_valid;
   assign burst_open  = rsp_valid && rsp_goal_valid && !rsp_last;
   assign index_ok    = rsp_servo_index != 6'd0 && rsp_servo_index <= 6'(SERVO_COUNT);
   assign goal_empty  = rsp_servo_index == 6'd0 && rsp_goal_position == 16'sd0;

   // a stalled result transaction keeps its payload
   `GFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_payload))

   // a goal transaction reports done and names a servo in range
   `GFR_ASSERT_NOW(a_goal_done, clock, reset, goal_out, rsp_status == ST_DONE && index_ok)

   // a status-only transaction is a lone final result with empty goal fields
   `GFR_ASSERT_NOW(a_status_only, clock, reset, status_out, rsp_last && goal_empty)

   // no request is taken while a goal burst is still draining
   `GFR_ASSERT_NOW(a_drain_blocks, clock, reset, burst_open, req_stall)

endmodule

bind goal_frame_receiver gfr_checker #(.SERVO_COUNT(SERVO_COUNT)) u_gfr_checker (.*);
